// File: design/ycbcr_chroma_gaussian_blur_core_defines.svh
// ----------------------------------------------------------------------------
// assertion macros for the chroma blur core
// clocked, reset-qualified property checks
// ----------------------------------------------------------------------------
`ifndef YCBCR_CHROMA_GAUSSIAN_BLUR_CORE_DEFINES_SVH
`define YCBCR_CHROMA_GAUSSIAN_BLUR_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define YCB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define YCB_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define YCB_ASSERT(lbl, prop, msg)
`define YCB_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// File: design/ycb_pkg.sv
// ----------------------------------------------------------------------------
// ycb_pkg
// shared types, constants and colour arithmetic for the chroma blur core
// ----------------------------------------------------------------------------
package ycb_pkg;

  localparam int MaxWidth  = 4096;
  localparam int MaxHeight = 4096;
  localparam int MaxRadius = 7;
  localparam int LsRows    = 2 * MaxRadius + 2;
  localparam int ColW      = 12;
  localparam int RowW      = 12;
  localparam int SlotW     = 4;
  localparam int AddrW     = SlotW + ColW;
  localparam int TapW      = 4;

  localparam logic [2:0] RegWidth  = 3'd0;
  localparam logic [2:0] RegHeight = 3'd1;
  localparam logic [2:0] RegRadius = 3'd2;
  localparam logic [2:0] RegTapLo  = 3'd3;
  localparam logic [2:0] RegTapHi  = 3'd4;

  localparam logic ModePixel = 1'b0;
  localparam logic ModeFlush = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_VREAD,
    ST_VWAIT,
    ST_VDONE,
    ST_HDONE,
    ST_LUMA,
    ST_COLOUR,
    ST_OUT
  } ycb_state_t;

  // controller to datapath
  typedef struct packed {
    logic       clr_h;     // start a new output pixel
    logic       clr_v;     // start a new column
    logic       rd_en;     // line store read at current tap
    logic       acc_v;     // accumulate vertical product
    logic       fin_v;     // finish column and add into horizontal sum
    logic       fin_h;     // finish horizontal sum
    logic       rd_ctr;    // read centre pixel
    logic       luma;      // compute luma
    logic       colour;    // compute rgb
    logic [3:0] dx;        // tap index 0..14 horizontally
    logic [3:0] dy;        // tap index 0..14 vertically
  } ycb_cmd_t;

  typedef struct packed {
    logic [2:0] rad;
  } ycb_sts_t;

  function automatic logic [7:0] to_byte(input logic signed [37:0] v);
    logic [7:0] res;
    begin
      if (v < 0) res = 8'd0;
      else if (v[37:24] > 14'd255) res = 8'd255;
      else res = v[31:24];
      return res;
    end
  endfunction

  function automatic logic signed [19:0] sat_round(input logic signed [47:0] s);
    logic signed [47:0] t;
    logic signed [32:0] q;
    logic signed [19:0] res;
    begin
      t = s + 48'sd16384;
      q = t[47:15];
      if (q < -33'sd524288) res = -20'sd524288;
      else if (q > 33'sd524287) res = 20'sd524287;
      else res = q[19:0];
      return res;
    end
  endfunction

endpackage

// File: design/ycb_stream_if.sv
// ----------------------------------------------------------------------------
// ycb_in_if / ycb_out_if
// valid/ready channels carrying pixel words
// ----------------------------------------------------------------------------
interface ycb_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;
  modport source (output valid, mode, red_in, green_in, blue_in, input ready);
  modport sink (input valid, mode, red_in, green_in, blue_in, output ready);
endinterface

interface ycb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic       frame_last;
  modport source (output valid, red_out, green_out, blue_out, frame_last, input ready);
  modport sink (input valid, red_out, green_out, blue_out, frame_last, output ready);
endinterface

// File: design/ycb_datapath.sv
// ----------------------------------------------------------------------------
// ycb_datapath
// line store, chroma conversion, shared multiply-accumulate and rgb rebuild
// ----------------------------------------------------------------------------
module ycb_datapath (
  input  logic                  clk,
  input  ycb_pkg::ycb_cmd_t     cmd,
  input  logic                  wr_en,
  input  logic [ycb_pkg::AddrW-1:0] wr_addr,
  input  logic [23:0]           wr_data,
  input  logic [ycb_pkg::AddrW-1:0] rd_addr,
  input  logic [15:0]           wt_v,
  input  logic [15:0]           wt_h,
  output logic [7:0]            red_o,
  output logic [7:0]            green_o,
  output logic [7:0]            blue_o
);

  logic [23:0] mem [0:(1 << ycb_pkg::AddrW)-1];
  logic [23:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (cmd.rd_en || cmd.rd_ctr) rd_data_r <= mem[rd_addr];
  end

  // chroma from registered pixel
  logic signed [26:0] qb, qr;
  logic signed [16:0] cb8, cr8;
  logic signed [17:0] r18, g18, b18;
  always_comb begin
    r18 = {10'd0, rd_data_r[23:16]};
    g18 = {10'd0, rd_data_r[15:8]};
    b18 = {10'd0, rd_data_r[7:0]};
    qb = 27'sd8388736 - 27'(r18 * 18'sd11058) - 27'(g18 * 18'sd21710)
       + 27'(b18 * 18'sd32768);
    qr = 27'sd8388736 + 27'(r18 * 18'sd32768) - 27'(g18 * 18'sd27439)
       - 27'(b18 * 18'sd5329);
    cb8 = 17'(qb[26:8] - 19'sd32768);
    cr8 = 17'(qr[26:8] - 19'sd32768);
  end

  logic signed [47:0] vcb_r, vcr_r, hcb_r, hcr_r;
  logic signed [19:0] vcbs, vcrs, cbf_r, crf_r;
  logic signed [17:0] wv, wh;
  logic [7:0] y_r;
  logic [7:0] r_r, g_r, b_r;

  assign wv = {2'b00, wt_v};
  assign wh = {2'b00, wt_h};
  assign vcbs = ycb_pkg::sat_round(vcb_r);
  assign vcrs = ycb_pkg::sat_round(vcr_r);

  logic signed [37:0] yq, rq, gq, bq;
  always_comb begin
    yq = 38'(y_r) <<< 24;
    rq = yq + 38'(crf_r * 18'sd91881);
    gq = yq - 38'(cbf_r * 18'sd22553) - 38'(crf_r * 18'sd46802);
    bq = yq + 38'(cbf_r * 18'sd116130);
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_h) begin
      hcb_r <= '0;
      hcr_r <= '0;
    end else if (cmd.fin_v) begin
      hcb_r <= hcb_r + 48'(vcbs * wh);
      hcr_r <= hcr_r + 48'(vcrs * wh);
    end
    if (cmd.clr_v) begin
      vcb_r <= '0;
      vcr_r <= '0;
    end else if (cmd.acc_v) begin
      vcb_r <= vcb_r + 48'(cb8 * wv);
      vcr_r <= vcr_r + 48'(cr8 * wv);
    end
    if (cmd.fin_h) begin
      cbf_r <= ycb_pkg::sat_round(hcb_r);
      crf_r <= ycb_pkg::sat_round(hcr_r);
    end
    if (cmd.luma)
      y_r <= 8'((26'(rd_data_r[23:16]) * 26'd19595 + 26'(rd_data_r[15:8]) * 26'd38470
               + 26'(rd_data_r[7:0]) * 26'd7471 + 26'd32768) >> 16);
    if (cmd.colour) begin
      r_r <= ycb_pkg::to_byte(rq);
      g_r <= ycb_pkg::to_byte(gq);
      b_r <= ycb_pkg::to_byte(bq);
    end
  end

  assign red_o   = r_r;
  assign green_o = g_r;
  assign blue_o  = b_r;

endmodule

// File: design/ycb_ctrl.sv
// ----------------------------------------------------------------------------
// ycb_ctrl
// sequencer: positions, tap walk over the window and output handshake
// ----------------------------------------------------------------------------
`include "ycbcr_chroma_gaussian_blur_core_defines.svh"
module ycb_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_mode,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_last,
  input  logic [12:0]           width_cfg,
  input  logic [12:0]           height_cfg,
  input  logic [2:0]            radius_cfg,
  input  logic [127:0]          taps,
  output ycb_pkg::ycb_cmd_t     cmd,
  output logic                  wr_en,
  output logic [ycb_pkg::AddrW-1:0] wr_addr,
  output logic [ycb_pkg::AddrW-1:0] rd_addr,
  output logic [15:0]           wt_v,
  output logic [15:0]           wt_h
);

  ycb_pkg::ycb_state_t state_r, state_nxt;
  logic [11:0] in_col_r, in_row_r, out_col_r, out_row_r;
  logic [11:0] in_col_nxt, in_row_nxt, out_col_nxt, out_row_nxt;
  logic        drain_r, drain_nxt, last_r, last_nxt;
  logic [3:0]  dx_r, dx_nxt, dy_r, dy_nxt;
  logic [24:0] p_r, p_nxt;

  logic [12:0] w, h;
  logic [2:0]  rad;
  ycb_pkg::ycb_sts_t sts;
  assign w   = (width_cfg == 13'd0) ? 13'd1 : ((width_cfg > 13'd4096) ? 13'd4096 : width_cfg);
  assign h   = (height_cfg == 13'd0) ? 13'd1 : ((height_cfg > 13'd4096) ? 13'd4096 : height_cfg);
  assign rad = radius_cfg;
  assign sts.rad = rad;

  logic [12:0] x, y;
  assign x = (13'(out_col_r) > w - 13'd1) ? w - 13'd1 : 13'(out_col_r);
  assign y = (13'(out_row_r) > h - 13'd1) ? h - 13'd1 : 13'(out_row_r);

  // tap offsets relative to centre: index - rad
  logic signed [14:0] cx, cy;
  logic [11:0] col, row;
  logic [4:0]  slot;
  assign cx = 15'(x) + 15'(dx_r) - 15'(sts.rad);
  assign cy = 15'(y) + 15'(dy_r) - 15'(sts.rad);
  assign col = (cx < 0) ? 12'd0 : ((cx > 15'(w) - 15'sd1) ? 12'(w - 13'd1) : cx[11:0]);
  assign row = (cy < 0) ? 12'd0 : ((cy > 15'(h) - 15'sd1) ? 12'(h - 13'd1) : cy[11:0]);

  logic [11:0] rsel;
  assign rsel = (state_r == ycb_pkg::ST_LUMA || state_r == ycb_pkg::ST_HDONE) ? y[11:0] : row;
  assign slot = 5'(rsel % 12'd16);
  assign rd_addr = {slot[3:0], (state_r == ycb_pkg::ST_HDONE) ? x[11:0] : col};

  function automatic logic [15:0] tapw(input logic [3:0] idx, input logic [2:0] r,
                                       input logic [127:0] t);
    logic [3:0] k;
    begin
      k = (idx >= 4'(r)) ? idx - 4'(r) : 4'(r) - idx;
      return t[16*k[2:0] +: 16];
    end
  endfunction

  // dy is one behind the read when accumulating
  logic [3:0] dy_d_r;
  always_ff @(posedge clk) dy_d_r <= dy_r;
  assign wt_v = tapw(dy_d_r, rad, taps);
  assign wt_h = tapw(dx_r, rad, taps);

  logic [24:0] lag;
  assign lag = 25'(rad) * 25'(w) + 25'(rad);

  logic accept;
  assign in_ready = (state_r == ycb_pkg::ST_IDLE);
  assign accept = in_valid && in_ready;
  assign wr_en = accept && (in_mode == ycb_pkg::ModePixel) && !drain_r;
  assign wr_addr = {4'(in_row_r % 12'd16), in_col_r};
  assign out_valid = (state_r == ycb_pkg::ST_OUT);
  assign out_last = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ycb_pkg::ST_IDLE;
      in_col_r <= '0; in_row_r <= '0; out_col_r <= '0; out_row_r <= '0;
      drain_r <= 1'b0; last_r <= 1'b0; dx_r <= '0; dy_r <= '0; p_r <= '0;
    end else begin
      state_r <= state_nxt;
      in_col_r <= in_col_nxt; in_row_r <= in_row_nxt;
      out_col_r <= out_col_nxt; out_row_r <= out_row_nxt;
      drain_r <= drain_nxt; last_r <= last_nxt;
      dx_r <= dx_nxt; dy_r <= dy_nxt; p_r <= p_nxt;
    end
  end

  logic [3:0] tmax;
  assign tmax = {rad, 1'b0};

  always_comb begin
    state_nxt = state_r;
    in_col_nxt = in_col_r; in_row_nxt = in_row_r;
    out_col_nxt = out_col_r; out_row_nxt = out_row_r;
    drain_nxt = drain_r; last_nxt = last_r;
    dx_nxt = dx_r; dy_nxt = dy_r; p_nxt = p_r;
    cmd = '0;
    cmd.dx = dx_r;
    cmd.dy = dy_r;
    case (state_r)
      ycb_pkg::ST_IDLE: begin
        if (accept) begin
          dx_nxt = '0; dy_nxt = '0;
          cmd.clr_h = 1'b1;
          cmd.clr_v = 1'b1;
          if (in_mode == ycb_pkg::ModeFlush) begin
            if (drain_r) state_nxt = ycb_pkg::ST_VREAD;
          end else if (!drain_r) begin
            p_nxt = 25'(in_row_r) * 25'(w) + 25'(in_col_r);
            if (13'(in_col_r) + 13'd1 >= w) begin
              in_col_nxt = '0;
              if (13'(in_row_r) + 13'd1 >= h) begin
                in_row_nxt = '0;
                drain_nxt = 1'b1;
              end else in_row_nxt = in_row_r + 12'd1;
            end else in_col_nxt = in_col_r + 12'd1;
            state_nxt = ycb_pkg::ST_VWAIT;
          end
        end
      end
      ycb_pkg::ST_VWAIT: begin
        // decide on the lag after the write lands
        state_nxt = (p_r >= lag) ? ycb_pkg::ST_VREAD : ycb_pkg::ST_IDLE;
      end
      ycb_pkg::ST_VREAD: begin
        cmd.rd_en = 1'b1;
        if (dy_r != 4'd0) cmd.acc_v = 1'b1;
        if (dy_r == tmax) state_nxt = ycb_pkg::ST_VDONE;
        else dy_nxt = dy_r + 4'd1;
      end
      ycb_pkg::ST_VDONE: begin
        cmd.acc_v = 1'b1;
        state_nxt = ycb_pkg::ST_LUMA;
      end
      ycb_pkg::ST_LUMA: begin
        // add finished column into horizontal sum
        cmd.fin_v = 1'b1;
        cmd.clr_v = 1'b0;
        if (dx_r == tmax) state_nxt = ycb_pkg::ST_HDONE;
        else begin
          dx_nxt = dx_r + 4'd1;
          dy_nxt = '0;
          state_nxt = ycb_pkg::ST_COLOUR;
        end
      end
      ycb_pkg::ST_COLOUR: begin
        // clear column sum between columns, then read again
        cmd.clr_v = 1'b1;
        state_nxt = ycb_pkg::ST_VREAD;
      end
      ycb_pkg::ST_HDONE: begin
        cmd.fin_h = 1'b1;
        cmd.rd_ctr = 1'b1;
        dx_nxt = '0;
        state_nxt = ycb_pkg::ST_OUT;
        last_nxt = (13'(out_col_r) + 13'd1 >= w) && (13'(out_row_r) + 13'd1 >= h);
      end
      ycb_pkg::ST_OUT: begin
        // dx used as a small phase count: luma, colour, then present
        if (dx_r == 4'd0) begin
          cmd.luma = 1'b1; dx_nxt = 4'd1;
        end else if (dx_r == 4'd1) begin
          cmd.colour = 1'b1; dx_nxt = 4'd2;
        end else if (out_ready) begin
          dx_nxt = '0;
          if (13'(out_col_r) + 13'd1 >= w) begin
            out_col_nxt = '0;
            out_row_nxt = last_r ? 12'd0 : out_row_r + 12'd1;
          end else out_col_nxt = out_col_r + 12'd1;
          if (last_r) drain_nxt = 1'b0;
          state_nxt = ycb_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ycb_pkg::ST_IDLE;
    endcase
  end

  logic out_fire;
  assign out_fire = (state_r == ycb_pkg::ST_OUT) && (dx_r == 4'd2) && out_ready;
  logic out_vis;
  assign out_vis = out_valid && (dx_r == 4'd2);

  `YCB_ASSERT(a_drain_end, out_fire && last_r |=> !drain_r, "drain not cleared on frame end")
  `YCB_ASSERT_NEVER(a_busy_ready, in_ready && state_r != ycb_pkg::ST_IDLE, "ready while busy")
  `YCB_ASSERT(a_tap_range, state_r == ycb_pkg::ST_VREAD |-> dy_r <= tmax, "tap out of window")

endmodule

// File: design/ycbcr_chroma_gaussian_blur_core.sv
// ----------------------------------------------------------------------------
// ycbcr_chroma_gaussian_blur_core
// rgb stream chroma blur: bt601 ycbcr, separable gaussian on cb/cr, back to rgb
// ----------------------------------------------------------------------------
// Usage: pixels enter raster order on the in_ channel (mode 0); after the last
// pixel of a frame, send flush words (mode 1) to drain the remaining outputs.
// An output word appears for input pixel q+R*W+R; frame_last marks the end.
// Registers over the cfg_ port (8-byte stride): width, height, radius, taps.
// Write them only while idle.
// Words are handled one at a time: a word is taken only once the previous one
// has been finished, as one shared multiply-accumulate walks the window
// through the single read port of the line store. A pixel that yields an
// output walks the whole window; a flush word does the same but skips the lag
// check, and pixels without output and ignored words skip the walk.
// Reset clears positions and control; the line store is not cleared.
// When the receiver stalls the result stays on out_ and no new word is taken.
// ----------------------------------------------------------------------------
module ycbcr_chroma_gaussian_blur_core (
  input  logic        clk,
  input  logic        rst_n,
  ycb_in_if.sink      in_ch,
  ycb_out_if.source   out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [5:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [12:0] width_r;
  logic [12:0] height_r;
  logic [2:0]  radius_r;
  logic [63:0] tlo_r, thi_r;
  logic [2:0]  ridx;

  assign cfg_pready = 1'b1;
  assign ridx = cfg_paddr[5:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= 13'd640; height_r <= 13'd480; radius_r <= 3'd2;
      tlo_r <= '0; thi_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (ridx)
        ycb_pkg::RegWidth:  width_r  <= cfg_pwdata[12:0];
        ycb_pkg::RegHeight: height_r <= cfg_pwdata[12:0];
        ycb_pkg::RegRadius: radius_r <= cfg_pwdata[2:0];
        ycb_pkg::RegTapLo:  tlo_r    <= cfg_pwdata;
        ycb_pkg::RegTapHi:  thi_r    <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      ycb_pkg::RegWidth:  cfg_prdata = {51'd0, width_r};
      ycb_pkg::RegHeight: cfg_prdata = {51'd0, height_r};
      ycb_pkg::RegRadius: cfg_prdata = {61'd0, radius_r};
      ycb_pkg::RegTapLo:  cfg_prdata = tlo_r;
      ycb_pkg::RegTapHi:  cfg_prdata = thi_r;
      default:            cfg_prdata = '0;
    endcase
  end

  ycb_pkg::ycb_cmd_t cmd;
  logic wr_en;
  logic [ycb_pkg::AddrW-1:0] wr_addr, rd_addr;
  logic [15:0] wt_v, wt_h;
  logic ov;

  ycb_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid (in_ch.valid), .in_ready (in_ch.ready), .in_mode (in_ch.mode),
    .out_valid (ov), .out_ready (out_ch.ready), .out_last (out_ch.frame_last),
    .width_cfg (width_r), .height_cfg (height_r), .radius_cfg (radius_r),
    .taps ({thi_r, tlo_r}),
    .cmd, .wr_en, .wr_addr, .rd_addr, .wt_v, .wt_h
  );

  // present only once colour is settled
  assign out_ch.valid = ov && (cmd.dx == 4'd2);

  ycb_datapath u_dp (
    .clk, .cmd, .wr_en, .wr_addr,
    .wr_data ({in_ch.red_in, in_ch.green_in, in_ch.blue_in}),
    .rd_addr, .wt_v, .wt_h,
    .red_o (out_ch.red_out), .green_o (out_ch.green_out), .blue_o (out_ch.blue_out)
  );

endmodule
